// ----- sv/cat_pkg.sv -----
// Shared types and constants for the compacting array table.
package cat_pkg;

  // Fixed field widths of the stream payload
  localparam int ActW = 2;
  localparam int ValW = 32;
  localparam int PosW = 5;
  localparam int StsW = 2;

  // Action carried on the input tuser
  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_LIST   = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_DELETE = 2'd3
  } cat_action_e;

  // Result status carried on the output tuser
  typedef enum logic [StsW-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } cat_status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch the accepted item and arm the scan
    logic insert;  // append the value or report full
    logic scan;    // walk one entry per cycle unless stalled by a waiting result
    logic finish;  // emit the closing result of a scan
  } cat_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic scan_end;  // every entry has been read and processed
  } cat_sts_t;

endpackage

// ----- sv/cat_ctrl.sv -----
// Controller state machine sequencing insert and scan operations.
module cat_ctrl import cat_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  cat_action_e in_action_i,
  input  cat_sts_t    sts_i,
  output logic        in_ready_o,
  output cat_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_SCAN = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_action_i == ACT_INSERT) ? S_INS : S_SCAN;
        end
      end
      S_INS: begin
        if (sts_i.out_free) begin
          cmd_o.insert = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/cat_dp.sv -----
// Datapath: entry memory, fill count, scan counters and result register.
module cat_dp import cat_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cat_cmd_t               cmd_i,
  output cat_sts_t               sts_o,
  input  cat_action_e            in_action_i,
  input  logic [ValW-1:0]        in_value_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output cat_status_e            out_status_o,
  output logic [PosW-1:0]        out_position_o,
  output logic signed [ValW-1:0] out_entry_value_o,
  output logic                   out_last_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > PosW) ? CW : PosW;

  // Fit a count into the position field, dropping high bits
  function automatic logic [PosW-1:0] to_pos(logic [CW-1:0] x);
    logic [XW-1:0] e;
    e = XW'(x);
    return e[PosW-1:0];
  endfunction

  // Entry memory
  logic [ValW-1:0] mem [DEPTH];
  logic [ValW-1:0] rdata_q;
  logic            mem_we, rd_en;
  logic [AW-1:0]   mem_waddr;
  logic [ValW-1:0] mem_wdata;

  // Control registers
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] kept_q, kept_d;
  logic          rv_q, rv_d;
  logic          pend_q, pend_d;
  logic          ov_q, ov_d;

  // Payload registers
  cat_action_e     act_q, act_d;
  logic [ValW-1:0] val_q, val_d;
  logic [CW-1:0]   pidx_q, pidx_d;
  logic [PosW-1:0] pend_pos_q, pend_pos_d;
  logic [ValW-1:0] pend_val_q, pend_val_d;
  cat_status_e     o_status_q, o_status_d;
  logic [PosW-1:0] o_pos_q, o_pos_d;
  logic [ValW-1:0] o_val_q, o_val_d;
  logic            o_last_q, o_last_d;

  logic out_free, is_list, is_del, eq, hit, stall, full;

  assign out_free       = !ov_q || out_ready_i;
  assign is_list        = (act_q == ACT_LIST);
  assign is_del         = (act_q == ACT_DELETE);
  assign eq             = (rdata_q == val_q);
  assign hit            = is_list || eq;
  assign stall          = !is_del && rv_q && hit && pend_q && !out_free;
  assign full           = (fill_q == CW'(DEPTH));
  assign sts_o.out_free = out_free;
  assign sts_o.scan_end = !rv_q && (rd_idx_q == fill_q);

  // Operation sequencing and result formation
  always_comb begin
    fill_d     = fill_q;
    rd_idx_d   = rd_idx_q;
    kept_d     = kept_q;
    rv_d       = rv_q;
    pend_d     = pend_q;
    act_d      = act_q;
    val_d      = val_q;
    pidx_d     = pidx_q;
    pend_pos_d = pend_pos_q;
    pend_val_d = pend_val_q;
    ov_d       = ov_q && !out_ready_i;
    o_status_d = o_status_q;
    o_pos_d    = o_pos_q;
    o_val_d    = o_val_q;
    o_last_d   = o_last_q;
    mem_we     = 1'b0;
    mem_waddr  = fill_q[AW-1:0];
    mem_wdata  = val_q;
    rd_en      = 1'b0;

    // Latch the accepted item and restart the walk
    if (cmd_i.load) begin
      act_d    = in_action_i;
      val_d    = in_value_i;
      rd_idx_d = '0;
      kept_d   = '0;
      rv_d     = 1'b0;
      pend_d   = 1'b0;
    end

    // Append or reject
    if (cmd_i.insert) begin
      ov_d     = 1'b1;
      o_val_d  = '0;
      o_last_d = 1'b1;
      if (full) begin
        o_status_d = ST_FULL;
        o_pos_d    = to_pos(fill_q);
      end else begin
        mem_we     = 1'b1;
        fill_d     = CW'(fill_q + CW'(1));
        o_status_d = ST_DONE;
        o_pos_d    = to_pos(CW'(fill_q + CW'(1)));
      end
    end

    // Process the fetched entry and fetch the next one
    if (cmd_i.scan && !stall) begin
      if (rv_q) begin
        if (is_del) begin
          if (!eq) begin
            mem_we    = 1'b1;
            mem_waddr = kept_q[AW-1:0];
            mem_wdata = rdata_q;
            kept_d    = CW'(kept_q + CW'(1));
          end
        end else if (hit) begin
          if (pend_q) begin
            ov_d       = 1'b1;
            o_status_d = ST_DONE;
            o_pos_d    = pend_pos_q;
            o_val_d    = pend_val_q;
            o_last_d   = 1'b0;
          end
          pend_d     = 1'b1;
          pend_pos_d = to_pos(CW'(pidx_q + CW'(1)));
          pend_val_d = rdata_q;
        end
      end
      if (rd_idx_q != fill_q) begin
        rd_en    = 1'b1;
        rv_d     = 1'b1;
        pidx_d   = rd_idx_q;
        rd_idx_d = CW'(rd_idx_q + CW'(1));
      end else begin
        rv_d = 1'b0;
      end
    end

    // Close the walk with the final result
    if (cmd_i.finish) begin
      ov_d     = 1'b1;
      o_last_d = 1'b1;
      o_val_d  = '0;
      if (is_del) begin
        fill_d     = kept_q;
        o_pos_d    = to_pos(CW'(fill_q - kept_q));
        o_status_d = (fill_q == kept_q) ? ST_NONE : ST_DONE;
      end else if (pend_q) begin
        o_status_d = ST_DONE;
        o_pos_d    = pend_pos_q;
        o_val_d    = pend_val_q;
      end else begin
        o_status_d = ST_NONE;
        o_pos_d    = '0;
      end
      pend_d = 1'b0;
    end
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_idx_q[AW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      rd_idx_q <= '0;
      kept_q   <= '0;
      rv_q     <= 1'b0;
      pend_q   <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      rd_idx_q <= rd_idx_d;
      kept_q   <= kept_d;
      rv_q     <= rv_d;
      pend_q   <= pend_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    val_q      <= val_d;
    pidx_q     <= pidx_d;
    pend_pos_q <= pend_pos_d;
    pend_val_q <= pend_val_d;
    o_status_q <= o_status_d;
    o_pos_q    <= o_pos_d;
    o_val_q    <= o_val_d;
    o_last_q   <= o_last_d;
  end

  assign out_valid_o       = ov_q;
  assign out_status_o      = o_status_q;
  assign out_position_o    = o_pos_q;
  assign out_entry_value_o = o_val_q;
  assign out_last_o        = o_last_q;

  // Fill count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= CW'(DEPTH))
    else $error("fill count above depth");

  // Compaction never writes ahead of the read pointer
  assert property (@(posedge clk_i) disable iff (!rst_ni) kept_q <= rd_idx_q)
    else $error("kept count ahead of read pointer");

  // The walk never reads beyond the filled part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.scan |-> rd_idx_q <= fill_q)
    else $error("scan read pointer beyond fill count");

  // A held match only exists for list and search
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q |-> !is_del)
    else $error("pending match during delete");

endmodule

// ----- sv/compacting_array_table_core.sv -----
// Top level of the compacting array table: stream ports around controller and datapath.
// An unsorted table of up to DEPTH signed 32-bit entries with a fill count. Each input
// transfer carries an action on tuser (insert, list, search, delete) and a value on tdata.
// Items are handled one at a time. Insert registers its result from the S_INS state once
// the output register is free, and the next item is taken when the controller is back in
// S_IDLE. List, search and delete walk the stored entries through the single read port
// of the entry memory, one entry per cycle unless a result waits for the output register.
// Their final result is registered from the S_DONE state at the end of the walk, and the
// next item is taken when the controller is back in S_IDLE. The insert result, every
// list or search result and every final result wait for the output register to free up
// while tready is low. Delete compacts the table in the same walk. Every operation ends
// with a result flagged by tlast. Entry memory needs no clearing after reset.
module compacting_array_table_core import cat_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [4:0] position, [36:5] entry_value, [39:37] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] status
  output logic        m_axis_tlast_o
);

  cat_cmd_t               cmd;
  cat_sts_t               sts;
  cat_action_e            in_action;
  cat_status_e            out_status;
  logic [PosW-1:0]        out_position;
  logic signed [ValW-1:0] out_entry_value;

  assign in_action = cat_action_e'(s_axis_tuser_i);

  cat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (in_action),
    .sts_i       (sts),
    .in_ready_o  (s_axis_tready_o),
    .cmd_o       (cmd)
  );

  cat_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .in_action_i       (in_action),
    .in_value_i        (s_axis_tdata_i),
    .out_ready_i       (m_axis_tready_i),
    .out_valid_o       (m_axis_tvalid_o),
    .out_status_o      (out_status),
    .out_position_o    (out_position),
    .out_entry_value_o (out_entry_value),
    .out_last_o        (m_axis_tlast_o)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {3'b000, out_entry_value, out_position};
  assign m_axis_tuser_o = out_status;

endmodule
